FILE: rtl/core/skc_pkg.sv
// shared constants and command codes for the sorted knot insert interpolator
package skc_pkg;

    localparam int KNOT_DEPTH_DEF = 32;
    localparam int WAVE_BITS_DEF  = 24;
    localparam int VALUE_BITS_DEF = 32;
    localparam int QUEUE_DEPTH    = 2;

    localparam int CMD_BITS = 2;
    localparam logic [CMD_BITS-1:0] CMD_CLEAR  = 2'd0;
    localparam logic [CMD_BITS-1:0] CMD_APPEND = 2'd1;
    localparam logic [CMD_BITS-1:0] CMD_SAMPLE = 2'd2;

endpackage

FILE: rtl/core/skc_fifo.sv
// small first-in first-out queue with push/full and pop/empty sides
module skc_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = skc_pkg::QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr;
    logic [AW-1:0]    r_rd;
    logic [CW-1:0]    r_cnt;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            r_cnt <= r_cnt + CW'(do_push) - CW'(do_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

FILE: rtl/core/skc_front.sv
// input side: drops unused commands, masks the final flag and queues jobs
module skc_front #(
    parameter int WAVE_BITS  = skc_pkg::WAVE_BITS_DEF,
    parameter int VALUE_BITS = skc_pkg::VALUE_BITS_DEF,
    parameter int JOB_BITS   = skc_pkg::CMD_BITS + 1 + WAVE_BITS + VALUE_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic [skc_pkg::CMD_BITS-1:0]  i_command,
    input  logic [WAVE_BITS-1:0]          i_wavelength,
    input  logic signed [VALUE_BITS-1:0]  i_sample_value,
    input  logic                          i_final_sample,
    input  logic                          i_job_pop,
    output logic [JOB_BITS-1:0]           o_job,
    output logic                          o_job_empty
);

    logic                keep;
    logic                fin;
    logic [JOB_BITS-1:0] job;

    // unused command codes are taken and dropped here
    assign keep = (i_command == skc_pkg::CMD_CLEAR) ||
                  (i_command == skc_pkg::CMD_APPEND) ||
                  (i_command == skc_pkg::CMD_SAMPLE);
    assign fin  = (i_command == skc_pkg::CMD_SAMPLE) && i_final_sample;
    assign job  = {i_command, fin, i_wavelength, i_sample_value};

    skc_fifo #(
        .WIDTH (JOB_BITS),
        .DEPTH (skc_pkg::QUEUE_DEPTH)
    ) u_job_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push && keep),
        .i_data  (job),
        .o_full  (full),
        .i_pop   (i_job_pop),
        .o_data  (o_job),
        .o_empty (o_job_empty)
    );

endmodule

FILE: rtl/core/skc_muldiv.sv
// bit-serial floor(mag * off / dx), one bit of mag per cycle, off < dx
module skc_muldiv #(
    parameter int WAVE_BITS  = skc_pkg::WAVE_BITS_DEF,
    parameter int VALUE_BITS = skc_pkg::VALUE_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [VALUE_BITS:0]  i_mag,
    input  logic [WAVE_BITS-1:0] i_off,
    input  logic [WAVE_BITS-1:0] i_dx,
    output logic                 o_done,
    output logic [VALUE_BITS:0]  o_quot
);

    localparam int SW = $clog2(VALUE_BITS + 2);
    localparam int RW = WAVE_BITS + 2;

    logic                 r_busy;
    logic                 r_done;
    logic [SW-1:0]        r_step;
    logic [VALUE_BITS:0]  r_mag;
    logic [VALUE_BITS:0]  r_q;
    logic [WAVE_BITS-1:0] r_rem;
    logic [WAVE_BITS-1:0] r_off;
    logic [WAVE_BITS-1:0] r_dx;

    logic [RW-1:0]        sum;
    logic [RW-1:0]        dx1;
    logic [RW-1:0]        dx2;
    logic [RW-1:0]        n_rem;
    logic [1:0]           n_t;

    // 2*rem + bit*off stays below 3*dx, so the quotient digit is 0, 1 or 2
    always_comb begin
        dx1 = {2'b00, r_dx};
        dx2 = {1'b0, r_dx, 1'b0};
        sum = {1'b0, r_rem, 1'b0} + (r_mag[VALUE_BITS] ? {2'b00, r_off} : '0);
        if (sum >= dx2) begin
            n_rem = sum - dx2;
            n_t   = 2'd2;
        end else if (sum >= dx1) begin
            n_rem = sum - dx1;
            n_t   = 2'd1;
        end else begin
            n_rem = sum;
            n_t   = 2'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                if (r_step == SW'(VALUE_BITS)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_step <= r_step + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_mag <= i_mag;
            r_off <= i_off;
            r_dx  <= i_dx;
            r_q   <= '0;
            r_rem <= '0;
        end else if (r_busy) begin
            r_mag <= {r_mag[VALUE_BITS-1:0], 1'b0};
            r_q   <= {r_q[VALUE_BITS-1:0], 1'b0} + (VALUE_BITS + 1)'(n_t);
            r_rem <= n_rem[WAVE_BITS-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

FILE: rtl/core/skc_back.sv
// execution side: knot store, spectrum position and the merge sequencer
module skc_back #(
    parameter int KNOT_DEPTH = skc_pkg::KNOT_DEPTH_DEF,
    parameter int WAVE_BITS  = skc_pkg::WAVE_BITS_DEF,
    parameter int VALUE_BITS = skc_pkg::VALUE_BITS_DEF,
    parameter int JOB_BITS   = skc_pkg::CMD_BITS + 1 + WAVE_BITS + VALUE_BITS,
    parameter int RES_BITS   = WAVE_BITS + VALUE_BITS + 3
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic [JOB_BITS-1:0]  i_job,
    input  logic                 i_job_empty,
    output logic                 o_job_pop,
    output logic                 o_div_start,
    output logic [VALUE_BITS:0]  o_div_mag,
    output logic [WAVE_BITS-1:0] o_div_off,
    output logic [WAVE_BITS-1:0] o_div_dx,
    input  logic                 i_div_done,
    input  logic [VALUE_BITS:0]  i_div_quot,
    output logic                 o_res_push,
    output logic [RES_BITS-1:0]  o_res_data,
    input  logic                 i_res_full
);

    localparam int IW = (KNOT_DEPTH > 1) ? $clog2(KNOT_DEPTH) : 1;
    localparam int CW = $clog2(KNOT_DEPTH + 1);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SCAN  = 3'd1;
    localparam logic [2:0] ST_CHK   = 3'd2;
    localparam logic [2:0] ST_DIV   = 3'd3;
    localparam logic [2:0] ST_PUSHK = 3'd4;
    localparam logic [2:0] ST_EMIT  = 3'd5;

    logic [2:0]                    r_state;
    logic [CW-1:0]                 r_cnt;
    logic [CW-1:0]                 r_ptr;
    logic                          r_have_prev;
    logic [WAVE_BITS-1:0]          r_prev_w;
    logic [VALUE_BITS-1:0]         r_prev_y;
    logic [WAVE_BITS-1:0]          r_w;
    logic [VALUE_BITS-1:0]         r_y;
    logic                          r_fin;
    logic [WAVE_BITS-1:0]          r_knot;
    logic [WAVE_BITS-1:0]          r_kw;
    logic                          r_neg;
    logic [VALUE_BITS-1:0]         r_ival;
    logic [WAVE_BITS-1:0]          r_mem [KNOT_DEPTH];

    logic [skc_pkg::CMD_BITS-1:0]  job_kind;
    logic                          job_fin;
    logic [WAVE_BITS-1:0]          job_wave;
    logic [VALUE_BITS-1:0]         job_value;
    logic                          take;
    logic                          mem_we;
    logic                          emit_knot;
    logic signed [VALUE_BITS:0]    dy;
    logic [VALUE_BITS:0]           prev_ext;
    logic [VALUE_BITS:0]           ival;

    assign job_kind  = i_job[JOB_BITS-1 -: skc_pkg::CMD_BITS];
    assign job_fin   = i_job[WAVE_BITS + VALUE_BITS];
    assign job_wave  = i_job[VALUE_BITS +: WAVE_BITS];
    assign job_value = i_job[VALUE_BITS-1:0];

    assign take      = (r_state == ST_IDLE) && !i_job_empty;
    assign o_job_pop = take;
    assign mem_we    = take && (job_kind == skc_pkg::CMD_APPEND) &&
                       (r_cnt < CW'(KNOT_DEPTH));

    // knot strictly inside the open interval between the two samples
    assign emit_knot = r_have_prev && (r_knot > r_prev_w) && (r_knot < r_w);

    assign dy        = $signed({r_y[VALUE_BITS-1], r_y}) -
                       $signed({r_prev_y[VALUE_BITS-1], r_prev_y});
    assign o_div_mag = dy[VALUE_BITS] ? (VALUE_BITS + 1)'(-dy) : dy;
    assign o_div_off = r_knot - r_prev_w;
    assign o_div_dx  = r_w - r_prev_w;
    assign o_div_start = (r_state == ST_CHK) && (r_knot <= r_w) && emit_knot;

    assign prev_ext  = {r_prev_y[VALUE_BITS-1], r_prev_y};
    assign ival      = r_neg ? prev_ext - i_div_quot : prev_ext + i_div_quot;

    always_comb begin
        o_res_push = 1'b0;
        o_res_data = {r_w, r_y, 1'b0, 1'b1, r_fin};
        unique case (r_state)
            ST_PUSHK: begin
                o_res_push = !i_res_full;
                o_res_data = {r_kw, r_ival, 1'b1, 1'b0, 1'b0};
            end
            ST_EMIT: begin
                o_res_push = !i_res_full;
            end
            default: begin
                o_res_push = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_ptr       <= '0;
            r_have_prev <= 1'b0;
            r_prev_w    <= '0;
            r_prev_y    <= '0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (take) begin
                        priority if (job_kind == skc_pkg::CMD_CLEAR) begin
                            r_cnt <= '0;
                            r_ptr <= '0;
                        end else if (job_kind == skc_pkg::CMD_APPEND) begin
                            if (mem_we) begin
                                r_cnt <= r_cnt + 1'b1;
                            end
                        end else begin
                            r_state <= ST_SCAN;
                        end
                    end
                end
                ST_SCAN: begin
                    r_state <= (r_ptr < r_cnt) ? ST_CHK : ST_EMIT;
                end
                ST_CHK: begin
                    if (r_knot > r_w) begin
                        r_state <= ST_EMIT;
                    end else begin
                        r_ptr   <= r_ptr + 1'b1;
                        r_state <= emit_knot ? ST_DIV : ST_SCAN;
                    end
                end
                ST_DIV: begin
                    if (i_div_done) begin
                        r_state <= ST_PUSHK;
                    end
                end
                ST_PUSHK: begin
                    if (!i_res_full) begin
                        r_state <= ST_SCAN;
                    end
                end
                ST_EMIT: begin
                    if (!i_res_full) begin
                        if (r_fin) begin
                            r_ptr       <= '0;
                            r_have_prev <= 1'b0;
                        end else begin
                            r_prev_w    <= r_w;
                            r_prev_y    <= r_y;
                            r_have_prev <= 1'b1;
                        end
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_w   <= job_wave;
            r_y   <= job_value;
            r_fin <= job_fin;
        end
        if (o_div_start) begin
            r_kw  <= r_knot;
            r_neg <= dy[VALUE_BITS];
        end
        if ((r_state == ST_DIV) && i_div_done) begin
            r_ival <= ival[VALUE_BITS-1:0];
        end
    end

    // knot store, registered read at the scan pointer
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_cnt[IW-1:0]] <= job_wave;
        end
        if (r_ptr < r_cnt) begin
            r_knot <= r_mem[r_ptr[IW-1:0]];
        end
    end

endmodule

FILE: rtl/core/sorted_knot_insert_interpolator.sv
// a sample with no knot left to scan goes from idle through scan to emit and the result side
// inserted knots go through check, divide and push; divide waits for the multiply-divide unit
// a passed knot goes through scan and check; a larger one ends the scan; clear/append in idle
// reset is synchronous: clears both queues, knot count, pointer and spectrum position
// the knot store itself is not cleared; only entries below the count are ever read
module sorted_knot_insert_interpolator #(
    parameter int KNOT_DEPTH = skc_pkg::KNOT_DEPTH_DEF,
    parameter int WAVE_BITS  = skc_pkg::WAVE_BITS_DEF,
    parameter int VALUE_BITS = skc_pkg::VALUE_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic [skc_pkg::CMD_BITS-1:0]  i_command,
    input  logic [WAVE_BITS-1:0]          i_wavelength,
    input  logic signed [VALUE_BITS-1:0]  i_sample_value,
    input  logic                          i_final_sample,
    output logic                          empty,
    input  logic                          pop,
    output logic [WAVE_BITS-1:0]          o_out_wavelength,
    output logic signed [VALUE_BITS-1:0]  o_out_value,
    output logic                          o_inserted,
    output logic                          o_run_last,
    output logic                          o_spectrum_end
);

    localparam int JOB_BITS = skc_pkg::CMD_BITS + 1 + WAVE_BITS + VALUE_BITS;
    localparam int RES_BITS = WAVE_BITS + VALUE_BITS + 3;

    logic [JOB_BITS-1:0]  job;
    logic                 job_empty;
    logic                 job_pop;
    logic                 div_start;
    logic [VALUE_BITS:0]  div_mag;
    logic [WAVE_BITS-1:0] div_off;
    logic [WAVE_BITS-1:0] div_dx;
    logic                 div_done;
    logic [VALUE_BITS:0]  div_quot;
    logic                 res_push;
    logic [RES_BITS-1:0]  res_in;
    logic                 res_full;
    logic [RES_BITS-1:0]  res_out;

    skc_front #(
        .WAVE_BITS  (WAVE_BITS),
        .VALUE_BITS (VALUE_BITS),
        .JOB_BITS   (JOB_BITS)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .full           (full),
        .i_command      (i_command),
        .i_wavelength   (i_wavelength),
        .i_sample_value (i_sample_value),
        .i_final_sample (i_final_sample),
        .i_job_pop      (job_pop),
        .o_job          (job),
        .o_job_empty    (job_empty)
    );

    skc_back #(
        .KNOT_DEPTH (KNOT_DEPTH),
        .WAVE_BITS  (WAVE_BITS),
        .VALUE_BITS (VALUE_BITS),
        .JOB_BITS   (JOB_BITS),
        .RES_BITS   (RES_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job       (job),
        .i_job_empty (job_empty),
        .o_job_pop   (job_pop),
        .o_div_start (div_start),
        .o_div_mag   (div_mag),
        .o_div_off   (div_off),
        .o_div_dx    (div_dx),
        .i_div_done  (div_done),
        .i_div_quot  (div_quot),
        .o_res_push  (res_push),
        .o_res_data  (res_in),
        .i_res_full  (res_full)
    );

    skc_muldiv #(
        .WAVE_BITS  (WAVE_BITS),
        .VALUE_BITS (VALUE_BITS)
    ) u_muldiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_mag   (div_mag),
        .i_off   (div_off),
        .i_dx    (div_dx),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    skc_fifo #(
        .WIDTH (RES_BITS),
        .DEPTH (skc_pkg::QUEUE_DEPTH)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res_in),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_data  (res_out),
        .o_empty (empty)
    );

    assign o_out_wavelength = res_out[RES_BITS-1 -: WAVE_BITS];
    assign o_out_value      = res_out[3 +: VALUE_BITS];
    assign o_inserted       = res_out[2];
    assign o_run_last       = res_out[1];
    assign o_spectrum_end   = res_out[0];

`ifndef SYNTHESIS
    a_res_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_push |-> !res_full)
        else $error("result written into a full queue");

    a_job_pop_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        job_pop |-> !job_empty)
        else $error("job taken from an empty queue");

    a_div_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_start |=> !div_start && !div_done)
        else $error("divider restarted or finished too early");

    a_done_no_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> !res_push && !div_start)
        else $error("divider result overlaps a result transfer");
`endif

endmodule

FILE: bench/tb_top.sv
// self-checking bench for the sorted knot insert interpolator: directed, full store, random
`timescale 1ns / 100ps

module tb_top;

    localparam int KD = skc_pkg::KNOT_DEPTH_DEF;
    localparam int WB = skc_pkg::WAVE_BITS_DEF;
    localparam int VB = skc_pkg::VALUE_BITS_DEF;
    localparam int CB = skc_pkg::CMD_BITS;

    localparam logic [CB-1:0] CMD_UNUSED = 2'd3;

    localparam logic [WB-1:0]        WAVE_MAX  = {WB{1'b1}};
    localparam logic signed [VB-1:0] VALUE_MAX = {1'b0, {(VB-1){1'b1}}};
    localparam logic signed [VB-1:0] VALUE_MIN = {1'b1, {(VB-1){1'b0}}};

    localparam int    ITEM_TARGET  = 370;
    localparam int    SETTLE_CYCLES = 48;
    localparam longint TIMEOUT_NS  = 30_000_000;

    typedef struct {
        logic [WB-1:0]        wl;
        logic signed [VB-1:0] val;
        logic                 ins;
        logic                 run_last;
        logic                 spec_end;
    } t_point;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  push;
    logic                  full;
    logic [CB-1:0]         i_command;
    logic [WB-1:0]         i_wavelength;
    logic signed [VB-1:0]  i_sample_value;
    logic                  i_final_sample;
    logic                  empty;
    logic                  pop;
    logic [WB-1:0]         o_out_wavelength;
    logic signed [VB-1:0]  o_out_value;
    logic                  o_inserted;
    logic                  o_run_last;
    logic                  o_spectrum_end;

    sorted_knot_insert_interpolator u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .push             (push),
        .full             (full),
        .i_command        (i_command),
        .i_wavelength     (i_wavelength),
        .i_sample_value   (i_sample_value),
        .i_final_sample   (i_final_sample),
        .empty            (empty),
        .pop              (pop),
        .o_out_wavelength (o_out_wavelength),
        .o_out_value      (o_out_value),
        .o_inserted       (o_inserted),
        .o_run_last       (o_run_last),
        .o_spectrum_end   (o_spectrum_end)
    );

    // mirror of the block state
    logic [WB-1:0]        knot_copy [KD];
    int                   knot_total;
    int                   knot_idx;
    logic [WB-1:0]        last_wl;
    logic signed [VB-1:0] last_val;
    logic                 spectrum_open;

    t_point               pending_points [$];
    int                   mismatch_count;
    int                   items_sent;
    int                   send_calm;
    int                   pop_calm;
    logic [WB-1:0]        ramp [64];

    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    function automatic int draw_wait(inout int calm);
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 9) == 0) begin
            calm = $urandom_range(8, 40);
            return 0;
        end
        return $urandom_range(0, 17);
    endfunction

    function automatic logic signed [VB-1:0] lerp_value(
        input logic [WB-1:0] x0, input logic signed [VB-1:0] y0,
        input logic [WB-1:0] x1, input logic signed [VB-1:0] y1,
        input logic [WB-1:0] k);
        longint          dy;
        longint unsigned mag;
        longint unsigned q;
        longint          res;
        dy  = longint'(y1) - longint'(y0);
        mag = (dy < 0) ? -dy : dy;
        // exact product, then truncating divide
        q   = (mag * 64'(k - x0)) / 64'(x1 - x0);
        res = (dy < 0) ? longint'(y0) - longint'(q) : longint'(y0) + longint'(q);
        return res[VB-1:0];
    endfunction

    task automatic predict_points(input logic [CB-1:0] cmd, input logic [WB-1:0] wl,
                                  input logic signed [VB-1:0] val, input logic fin);
        t_point p;
        case (cmd)
            skc_pkg::CMD_CLEAR: begin
                knot_total = 0;
                knot_idx   = 0;
            end
            skc_pkg::CMD_APPEND: begin
                if (knot_total < KD) begin
                    knot_copy[knot_total] = wl;
                    knot_total++;
                end
            end
            skc_pkg::CMD_SAMPLE: begin
                while (knot_idx < knot_total && knot_copy[knot_idx] <= wl) begin
                    if (spectrum_open && knot_copy[knot_idx] > last_wl &&
                        knot_copy[knot_idx] < wl) begin
                        p.wl       = knot_copy[knot_idx];
                        p.val      = lerp_value(last_wl, last_val, wl, val, knot_copy[knot_idx]);
                        p.ins      = 1'b1;
                        p.run_last = 1'b0;
                        p.spec_end = 1'b0;
                        pending_points.push_back(p);
                    end
                    knot_idx++;
                end
                p.wl       = wl;
                p.val      = val;
                p.ins      = 1'b0;
                p.run_last = 1'b1;
                p.spec_end = fin;
                pending_points.push_back(p);
                if (fin) begin
                    knot_idx      = 0;
                    spectrum_open = 1'b0;
                end else begin
                    last_wl       = wl;
                    last_val      = val;
                    spectrum_open = 1'b1;
                end
            end
            default: ;
        endcase
    endtask

    task automatic send_item(input logic [CB-1:0] cmd, input logic [WB-1:0] wl,
                             input logic signed [VB-1:0] val, input logic fin);
        int gap;
        gap = draw_wait(send_calm);
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_command      <= cmd;
        i_wavelength   <= wl;
        i_sample_value <= val;
        i_final_sample <= fin;
        push           <= 1'b1;
        do @(posedge i_clk); while (full);
        predict_points(cmd, wl, val, fin);
        if (cmd != CMD_UNUSED)
            items_sent++;
    endtask

    // hold off until every expected result is out and the block is quiet
    task automatic wait_drained;
        push <= 1'b0;
        while (pending_points.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("%0t: mismatch on %s: got %0h, expected %0h", $time, what, got, want);
        mismatch_count++;
    endtask

    function automatic logic signed [VB-1:0] rand_value;
        case ($urandom_range(0, 7))
            0:       return VALUE_MIN;
            1:       return VALUE_MAX;
            2:       return VB'($urandom_range(0, 15)) - VB'(8);
            default: return VB'($urandom);
        endcase
    endfunction

    // ascending wavelengths in ramp[0..n-1], repeats allowed
    task automatic fill_ramp(input int n, input longint lo, input longint hi);
        longint cur;
        longint room;
        cur = lo;
        for (int i = 0; i < n; i++) begin
            room = hi - cur;
            cur += $urandom_range(0, int'(room / (n - i)));
            ramp[i] = WB'(cur);
        end
    endtask

    task automatic test_directed;
        send_item(skc_pkg::CMD_SAMPLE, 24'd500, 32'sd7, 1'b0);
        send_item(skc_pkg::CMD_SAMPLE, 24'd600, 32'sd9, 1'b1);
        send_item(skc_pkg::CMD_CLEAR, WAVE_MAX, VALUE_MAX, 1'b1);
        send_item(skc_pkg::CMD_APPEND, 24'd100, 32'sd0, 1'b0);
        send_item(skc_pkg::CMD_APPEND, 24'd200, 32'sd0, 1'b1);
        send_item(skc_pkg::CMD_APPEND, 24'd300, 32'sd0, 1'b0);
        send_item(skc_pkg::CMD_APPEND, 24'd300, 32'sd0, 1'b0);
        send_item(skc_pkg::CMD_APPEND, 24'd450, 32'sd0, 1'b0);
        send_item(skc_pkg::CMD_APPEND, WAVE_MAX, 32'sd0, 1'b0);
        // knot below the first sample is skipped
        send_item(skc_pkg::CMD_SAMPLE, 24'd150, VALUE_MIN, 1'b0);
        // knot equal to the sample
        send_item(skc_pkg::CMD_SAMPLE, 24'd200, 32'sd0, 1'b0);
        send_item(skc_pkg::CMD_SAMPLE, 24'd500, VALUE_MAX, 1'b0);
        // out of order sample
        send_item(skc_pkg::CMD_SAMPLE, 24'd400, -32'sd5, 1'b0);
        send_item(CMD_UNUSED, WAVE_MAX, VALUE_MIN, 1'b1);
        send_item(skc_pkg::CMD_SAMPLE, WAVE_MAX, VALUE_MIN, 1'b1);
        // same knots, fresh spectrum, falling slope
        send_item(skc_pkg::CMD_SAMPLE, 24'd0, VALUE_MAX, 1'b0);
        send_item(skc_pkg::CMD_SAMPLE, 24'd250, VALUE_MIN, 1'b0);
        send_item(skc_pkg::CMD_SAMPLE, 24'd300, 32'sd1, 1'b1);
        // clear in mid spectrum keeps the previous sample
        send_item(skc_pkg::CMD_SAMPLE, 24'd1000, 32'sd3, 1'b0);
        send_item(skc_pkg::CMD_CLEAR, 24'd0, 32'sd0, 1'b0);
        send_item(skc_pkg::CMD_APPEND, 24'd1500, 32'sd0, 1'b0);
        send_item(skc_pkg::CMD_APPEND, 24'd2000, 32'sd0, 1'b0);
        send_item(skc_pkg::CMD_SAMPLE, 24'd3000, -32'sd100, 1'b1);
    endtask

    task automatic test_full_store;
        send_item(skc_pkg::CMD_CLEAR, 24'd0, 32'sd0, 1'b0);
        // the last two appends overflow the store
        for (int i = 0; i < KD + 2; i++)
            send_item(skc_pkg::CMD_APPEND, WB'(i * 500000 + 1), 32'sd0, 1'b0);
        send_item(skc_pkg::CMD_SAMPLE, 24'd0, VALUE_MIN, 1'b0);
        send_item(skc_pkg::CMD_SAMPLE, WAVE_MAX, VALUE_MAX, 1'b1);
        wait_drained();
    endtask

    task automatic test_random_spectra;
        int     n_knots;
        int     n_samples;
        int     n_spectra;
        longint lo;
        longint hi;
        logic   fin;
        while (items_sent < ITEM_TARGET) begin
            if ($urandom_range(0, 7) == 0) begin
                // noise: any command, any field
                repeat ($urandom_range(1, 4))
                    send_item(CB'($urandom), WB'($urandom), VB'($urandom),
                              1'($urandom));
            end else begin
                lo = $urandom_range(0, int'(WAVE_MAX));
                if ($urandom_range(0, 2) == 0)
                    hi = lo + $urandom_range(0, 40);
                else
                    hi = lo + longint'($urandom_range(0, int'(WAVE_MAX)));
                if (hi > longint'(WAVE_MAX))
                    hi = WAVE_MAX;
                if ($urandom_range(0, 1) == 0)
                    send_item(skc_pkg::CMD_CLEAR, WB'($urandom), VB'($urandom),
                              1'($urandom));
                n_knots = ($urandom_range(0, 9) == 0) ? $urandom_range(20, KD + 2)
                                                      : $urandom_range(0, 6);
                fill_ramp(n_knots, lo, hi);
                for (int i = 0; i < n_knots; i++)
                    send_item(skc_pkg::CMD_APPEND, ramp[i], VB'($urandom), 1'($urandom));
                n_spectra = $urandom_range(1, 2);
                for (int s = 0; s < n_spectra; s++) begin
                    n_samples = $urandom_range(1, 6);
                    fill_ramp(n_samples, lo, hi);
                    for (int i = 0; i < n_samples; i++) begin
                        fin = (i == n_samples - 1) && ($urandom_range(0, 5) != 0);
                        send_item(skc_pkg::CMD_SAMPLE, ramp[i], rand_value(), fin);
                    end
                end
            end
        end
    endtask

    // result side: random stalls
    initial begin
        pop = 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            int gap;
            gap = draw_wait(pop_calm);
            if (gap > 0) begin
                pop <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            pop <= 1'b1;
            do @(posedge i_clk); while (empty);
        end
    end

    // compare every result transfer with the oldest expected point
    always @(posedge i_clk) begin
        t_point want;
        if (i_rst_n && pop && !empty) begin
            if (pending_points.size() == 0) begin
                report_mismatch("unexpected result wavelength", 64'(o_out_wavelength), 64'd0);
            end else begin
                want = pending_points.pop_front();
                if (o_out_wavelength !== want.wl)
                    report_mismatch("out_wavelength", 64'(o_out_wavelength), 64'(want.wl));
                if (o_out_value !== want.val)
                    report_mismatch("out_value", 64'(o_out_value), 64'(want.val));
                if (o_inserted !== want.ins)
                    report_mismatch("inserted", 64'(o_inserted), 64'(want.ins));
                if (o_run_last !== want.run_last)
                    report_mismatch("run_last", 64'(o_run_last), 64'(want.run_last));
                if (o_spectrum_end !== want.spec_end)
                    report_mismatch("spectrum_end", 64'(o_spectrum_end), 64'(want.spec_end));
            end
        end
    end

    initial begin
        #(TIMEOUT_NS);
        $display("** sorted_knot_insert_interpolator: FAILED **");
        $finish;
    end

    initial begin
        i_rst_n        = 1'b0;
        push           = 1'b0;
        i_command      = skc_pkg::CMD_CLEAR;
        i_wavelength   = '0;
        i_sample_value = '0;
        i_final_sample = 1'b0;
        knot_total     = 0;
        knot_idx       = 0;
        last_wl        = '0;
        last_val       = '0;
        spectrum_open  = 1'b0;
        mismatch_count = 0;
        items_sent     = 0;
        send_calm      = 0;
        pop_calm       = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_full_store();
        test_random_spectra();

        wait_drained();
        if (mismatch_count == 0 && pending_points.size() == 0)
            $display("** sorted_knot_insert_interpolator: PASSED **");
        else
            $display("** sorted_knot_insert_interpolator: FAILED **");
        $finish;
    end

endmodule

FILE: sorted_knot_insert_interpolator.f
rtl/core/skc_pkg.sv
rtl/core/skc_fifo.sv
rtl/core/skc_front.sv
rtl/core/skc_muldiv.sv
rtl/core/skc_back.sv
rtl/core/sorted_knot_insert_interpolator.sv
bench/tb_top.sv
